>>> hdl/lzss_stream_decoder_macros.svh
// Assertion helpers for the LZSS stream decoder.
// Both macros sample on clk and hold off while rst_n is low.
`ifndef LZSS_STREAM_DECODER_MACROS_SVH
`define LZSS_STREAM_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LZSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LZSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LZSS_ASSERT_IMP(label, ante, cons, msg)
`define LZSS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> hdl/lzss_pkg.sv
package lzss_pkg;

    // operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SOURCE = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd1;
    localparam logic [1:0] KIND_BUSY      = 2'd2;

    // queue sizes (powers of two)
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 4;
    localparam int OUT_CNT_W       = $clog2(OUT_QUEUE_DEPTH) + 1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] source_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       run_pending;
    } out_item_t;

    // decoded command, front to back
    typedef struct packed {
        logic       start;
        logic       source;
        logic       drain;
        logic [7:0] src_byte;
    } cmd_t;

    // header magic "NPK1"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4E;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h4B;
            2'd3:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/lzss_ram.sv
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/lzss_fifo.sv
module lzss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  logic [WIDTH-1:0]       push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output logic [WIDTH-1:0]       pop_data,
    output logic [$clog2(DEPTH):0] count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/lzss_front.sv
module lzss_front
    import lzss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  in_item_t src_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t                           cls;
    logic [$clog2(CMD_QUEUE_DEPTH):0] fill;

    // unused operation code becomes an empty command
    always_comb
    begin
        cls          = '0;
        cls.src_byte = src_item.source_byte;
        case (src_item.operation)
            OP_START:  cls.start  = 1'b1;
            OP_SOURCE: cls.source = 1'b1;
            OP_DRAIN:  cls.drain  = 1'b1;
            default:   ;
        endcase
    end

    lzss_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (src_valid),
        .push_ready (src_ready),
        .push_data  (cls),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_data   (cmd),
        .count      (fill)
    );

    // one entry is always free while the back keeps up
    logic unused_fill;
    assign unused_fill = ^fill;

endmodule

>>> hdl/lzss_back.sv
module lzss_back
    import lzss_pkg::*;
#(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    input  logic [OUT_CNT_W-1:0] out_count,
    output logic                 res_valid,
    output out_item_t            res_item
);

    localparam int AW = $clog2(WINDOW_SIZE);

    // token parser states
    localparam logic [1:0] PH_TOKEN = 2'd0;
    localparam logic [1:0] PH_DIST  = 2'd1;
    localparam logic [1:0] PH_EXT   = 2'd2;

    typedef struct packed {
        logic          res;
        logic [1:0]    kind;
        logic          from_win;
        logic          rd_ok;
        logic [AW-1:0] rd_addr;
        logic [7:0]    lit;
        logic          wr;
        logic [AW-1:0] wr_addr;
        logic          last;
        logic          pend;
    } stage_t;

    // stage A state
    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic [AW-1:0] cp_reg, cp_next;
    logic [8:0]    copy_rem_reg, copy_rem_next;
    logic [7:0]    flag_bits_reg, flag_bits_next;
    logic [3:0]    flags_left_reg, flags_left_next;
    logic [31:0]   out_left_reg, out_left_next;
    logic [3:0]    hdr_idx_reg, hdr_idx_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    mlow_reg, mlow_next;
    logic          hdr_failed_reg, hdr_failed_next;

    // stage B
    logic          b_valid_reg, b_valid_next;
    stage_t        stage_reg, stage_next;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;

    logic          take;
    logic          do_match;
    logic          do_emit;
    logic          from_win;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] cp_calc;
    logic [12:0]   match_dist;
    logic [8:0]    len_m1;
    logic [7:0]    ram_q;
    logic [7:0]    win_byte;
    logic [7:0]    byte_out;
    logic          b_res;
    logic          b_wr;

    assign b_res      = b_valid_reg && stage_reg.res;
    assign b_wr       = b_valid_reg && stage_reg.wr;
    // room for the item in B and one more
    assign cmd_ready  = (out_count + OUT_CNT_W'(b_res)) < OUT_CNT_W'(OUT_QUEUE_DEPTH);
    assign take       = cmd_valid && cmd_ready;
    assign match_dist = {1'b0, cmd.src_byte[7:4], mlow_reg} + 13'd1;
    assign cp_calc    = wp_reg - AW'(match_dist);

    always_comb
    begin
        wp_next         = wp_reg;
        wrapped_next    = wrapped_reg;
        cp_next         = cp_reg;
        copy_rem_next   = copy_rem_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        out_left_next   = out_left_reg;
        hdr_idx_next    = hdr_idx_reg;
        phase_next      = phase_reg;
        mlow_next       = mlow_reg;
        hdr_failed_next = hdr_failed_reg;
        b_valid_next    = take;
        stage_next      = '0;
        do_match        = 1'b0;
        do_emit         = 1'b0;
        from_win        = 1'b0;
        rd_addr         = cp_reg;
        len_m1          = '0;

        if (take)
        begin
            if (cmd.start)
            begin
                wp_next         = '0;
                wrapped_next    = 1'b0;
                cp_next         = '0;
                copy_rem_next   = '0;
                flag_bits_next  = '0;
                flags_left_next = '0;
                out_left_next   = '0;
                hdr_idx_next    = '0;
                phase_next      = PH_TOKEN;
                mlow_next       = '0;
                hdr_failed_next = 1'b0;
            end
            else if (!hdr_failed_reg)
            begin
                if (cmd.source)
                begin
                    if (copy_rem_reg != '0)
                    begin
                        stage_next.res  = 1'b1;
                        stage_next.kind = KIND_BUSY;
                        stage_next.pend = 1'b1;
                    end
                    else if (!hdr_idx_reg[3])
                    begin
                        if (!hdr_idx_reg[2])
                        begin
                            if (cmd.src_byte != magic_byte(hdr_idx_reg[1:0]))
                            begin
                                hdr_failed_next = 1'b1;
                                stage_next.res  = 1'b1;
                                stage_next.kind = KIND_BAD_MAGIC;
                            end
                            else
                            begin
                                hdr_idx_next = hdr_idx_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            // length, little-endian
                            case (hdr_idx_reg[1:0])
                                2'd0:    out_left_next[7:0]   = cmd.src_byte;
                                2'd1:    out_left_next[15:8]  = cmd.src_byte;
                                2'd2:    out_left_next[23:16] = cmd.src_byte;
                                2'd3:    out_left_next[31:24] = cmd.src_byte;
                                default: ;
                            endcase
                            hdr_idx_next = hdr_idx_reg + 4'd1;
                        end
                    end
                    else if (out_left_reg != '0)
                    begin
                        case (phase_reg)
                            PH_TOKEN:
                            begin
                                if (flags_left_reg == '0)
                                begin
                                    flag_bits_next  = cmd.src_byte;
                                    flags_left_next = 4'd8;
                                end
                                else
                                begin
                                    flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                                    flags_left_next = flags_left_reg - 4'd1;
                                    if (flag_bits_reg[0])
                                    begin
                                        do_emit = 1'b1;
                                    end
                                    else
                                    begin
                                        mlow_next  = cmd.src_byte;
                                        phase_next = PH_DIST;
                                    end
                                end
                            end
                            PH_DIST:
                            begin
                                cp_next = cp_calc;
                                if (cmd.src_byte[3:0] == 4'hF)
                                begin
                                    phase_next = PH_EXT;
                                end
                                else
                                begin
                                    do_match = 1'b1;
                                    rd_addr  = cp_calc;
                                    len_m1   = {5'd0, cmd.src_byte[3:0]} + 9'd2;
                                end
                            end
                            PH_EXT:
                            begin
                                do_match = 1'b1;
                                len_m1   = {1'b0, cmd.src_byte} + 9'd17;
                            end
                            default: ;
                        endcase
                    end
                end
                else if (cmd.drain)
                begin
                    if (copy_rem_reg != '0 && out_left_reg != '0)
                    begin
                        do_emit       = 1'b1;
                        from_win      = 1'b1;
                        cp_next       = cp_reg + 1'b1;
                        copy_rem_next = copy_rem_reg - 9'd1;
                    end
                end
            end
        end

        if (do_match)
        begin
            do_emit       = 1'b1;
            from_win      = 1'b1;
            cp_next       = rd_addr + 1'b1;
            copy_rem_next = len_m1;
            phase_next    = PH_TOKEN;
        end

        if (do_emit)
        begin
            wp_next       = wp_reg + 1'b1;
            wrapped_next  = wrapped_reg || (&wp_reg);
            out_left_next = out_left_reg - 32'd1;
            if (out_left_reg == 32'd1)
            begin
                copy_rem_next = '0;
            end
            stage_next.res      = 1'b1;
            stage_next.kind     = KIND_DATA;
            stage_next.from_win = from_win;
            // entries not yet written since start read as zero
            stage_next.rd_ok    = wrapped_reg || (rd_addr < wp_reg);
            stage_next.rd_addr  = rd_addr;
            stage_next.lit      = from_win ? 8'h00 : cmd.src_byte;
            stage_next.wr       = 1'b1;
            stage_next.wr_addr  = wp_reg;
            stage_next.last     = (out_left_reg == 32'd1);
            stage_next.pend     = (copy_rem_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            cp_reg         <= '0;
            copy_rem_reg   <= '0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            out_left_reg   <= '0;
            hdr_idx_reg    <= '0;
            phase_reg      <= PH_TOKEN;
            mlow_reg       <= '0;
            hdr_failed_reg <= 1'b0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            cp_reg         <= cp_next;
            copy_rem_reg   <= copy_rem_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            out_left_reg   <= out_left_next;
            hdr_idx_reg    <= hdr_idx_next;
            phase_reg      <= phase_next;
            mlow_reg       <= mlow_next;
            hdr_failed_reg <= hdr_failed_next;
            b_valid_reg    <= b_valid_next;
            fwd_valid_reg  <= b_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg    <= stage_next;
        fwd_addr_reg <= stage_reg.wr_addr;
        fwd_data_reg <= byte_out;
    end

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk     (clk),
        .wr_en   (b_wr),
        .wr_addr (stage_reg.wr_addr),
        .wr_data (byte_out),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // the previous write lands too late for this read
    assign win_byte = (fwd_valid_reg && fwd_addr_reg == stage_reg.rd_addr) ? fwd_data_reg :
                      (stage_reg.rd_ok ? ram_q : 8'h00);
    assign byte_out = stage_reg.from_win ? win_byte : stage_reg.lit;

    assign res_valid            = b_res;
    assign res_item.kind        = stage_reg.kind;
    assign res_item.data_byte   = byte_out;
    assign res_item.last_byte   = stage_reg.last;
    assign res_item.run_pending = stage_reg.pend;

endmodule

>>> hdl/lzss_stream_decoder.sv
// Streaming LZSS decompressor with a WINDOW_SIZE-byte history window. Items
// arrive on the src channel (start, compressed byte, or drain) and results
// leave on the res channel (decoded byte, bad magic, or busy). One item is
// taken per clock cycle when the result side keeps up; an item passes through
// the command queue, the parse stage that issues the window read, and the
// stage where the registered window RAM returns data and the byte is written
// back, before its result enters the output queue. The single window RAM read
// per cycle sets that rate; a byte written by the immediately preceding item is
// forwarded around the RAM. A start needs no clearing pass: the window tracks
// how far it has been filled since the start, and bytes beyond that read as
// zero. After reset the block behaves as after a start. The input side stalls
// only when the output queue is close to full.
`include "lzss_stream_decoder_macros.svh"

module lzss_stream_decoder
    import lzss_pkg::*;
#(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  in_item_t  src_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    // front to back
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_t      cmd;

    // back to output queue
    logic                 push_valid;
    logic                 push_ready;
    out_item_t            push_item;
    logic [OUT_CNT_W-1:0] out_count;

    // Front: decodes the operation and buffers commands.
    lzss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: header, flags and token parsing, window reads and writes.
    // It only takes a command when the output queue has room for it.
    lzss_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_count (out_count),
        .res_valid (push_valid),
        .res_item  (push_item)
    );

    // Output queue decouples the result consumer from the pipeline.
    lzss_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_res_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_item),
        .pop_valid  (res_valid),
        .pop_ready  (res_ready),
        .pop_data   (res_item),
        .count      (out_count)
    );

    // The credit check in the back must keep the output queue from overflowing.
    `LZSS_ASSERT_IMP(a_res_q_room, push_valid, push_ready, "result queue overflow")
    // A transferred item must reach the command queue.
    `LZSS_ASSERT_NXT(a_cmd_queued, src_valid && src_ready, cmd_valid, "command lost")
    // A start never produces a result.
    `LZSS_ASSERT_NXT(a_start_quiet, cmd_valid && cmd_ready && cmd.start, !push_valid,
                     "start produced a result")
    // A final byte never reports a pending match.
    `LZSS_ASSERT_IMP(a_last_no_run, push_valid && push_item.last_byte,
                     !push_item.run_pending && push_item.kind == KIND_DATA,
                     "last byte with pending run")

endmodule

>>> sim/lzss_stream_decoder_test.sv
module lzss_stream_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_pkg::*;

    localparam int WINDOW_BYTES = 4096;
    localparam int PTR_W = $clog2(WINDOW_BYTES);

    // operation 3 has no package name; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // "NPK1", first byte in the low lane
    localparam logic [31:0] STREAM_MAGIC = 32'h314B504E;

    localparam int STIMULUS_ITEMS = 1050;
    localparam int TAIL_CYCLES = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 40;

    typedef enum logic [1:0]
    {
        TOKEN_START,
        MATCH_HIGH,
        MATCH_EXTRA
    } parse_state_t;

    typedef enum logic [1:0]
    {
        RX_STEADY,
        RX_CHOPPY,
        RX_STARVED
    } rx_mode_t;

    // ---------------------------------------------------------------
    // Block ports; every input has a known value from time zero.
    // ---------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    in_item_t  src_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res_item;

    lzss_stream_decoder #(
        .WINDOW_SIZE(WINDOW_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_ready(src_ready),
        .src_item (src_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item (res_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Decoder shadow state: history window, parser position, and the
    // pending copy. A start and a reset both return it to all zeros.
    // ---------------------------------------------------------------
    logic [7:0]       win_bytes [WINDOW_BYTES];
    logic [PTR_W-1:0] win_wr;
    logic [PTR_W-1:0] win_rd;
    logic [8:0]       run_left;
    logic [7:0]       flag_shift;
    logic [3:0]       flag_count;
    logic [31:0]      total_len;
    logic [31:0]      total_out;
    logic [3:0]       hdr_pos;
    parse_state_t     parse_state;
    logic [7:0]       span_low;
    logic             magic_bad;

    out_item_t expected_results [$];
    in_item_t  compressed_items [$];

    int mismatch_count = 0;
    int cycle_count = 0;

    function automatic void clear_decoder();
        foreach (win_bytes[i])
            win_bytes[i] = 8'h00;
        win_wr = '0;
        win_rd = '0;
        run_left = '0;
        flag_shift = '0;
        flag_count = '0;
        total_len = '0;
        total_out = '0;
        hdr_pos = '0;
        parse_state = TOKEN_START;
        span_low = '0;
        magic_bad = 1'b0;
    endfunction

    // Every decoded byte goes into the window and is counted. Reaching the
    // header length marks the byte last and throws away any pending copy.
    function automatic void push_data(logic [7:0] b);
        out_item_t r;
        win_bytes[win_wr] = b;
        win_wr = win_wr + 1'b1;
        total_out = total_out + 32'd1;
        r.kind = KIND_DATA;
        r.data_byte = b;
        r.last_byte = (total_out == total_len);
        if (r.last_byte)
            run_left = '0;
        r.run_pending = (run_left != '0);
        expected_results.push_back(r);
    endfunction

    // Match token complete: first copy byte now, the rest on drains.
    function automatic void start_copy(logic [8:0] len);
        logic [7:0] b;
        b = win_bytes[win_rd];
        win_rd = win_rd + 1'b1;
        run_left = len - 9'd1;
        parse_state = TOKEN_START;
        push_data(b);
    endfunction

    function automatic void decode_step(in_item_t it);
        out_item_t r;
        logic [7:0] b;
        b = it.source_byte;
        r = '0;
        if (it.operation == OP_START)
        begin
            clear_decoder();
            return;
        end
        if (it.operation == OP_UNUSED || magic_bad)
            return;
        if (it.operation == OP_DRAIN)
        begin
            // drain with nothing pending, or after the stream ended: silent
            if (run_left != '0 && total_out < total_len)
            begin
                b = win_bytes[win_rd];
                win_rd = win_rd + 1'b1;
                run_left = run_left - 9'd1;
                push_data(b);
            end
            return;
        end
        // compressed byte while a copy is still pending: refused, no state change
        if (run_left != '0)
        begin
            r.kind = KIND_BUSY;
            r.run_pending = 1'b1;
            expected_results.push_back(r);
            return;
        end
        if (hdr_pos < 4'd8)
        begin
            if (hdr_pos < 4'd4)
            begin
                if (b != STREAM_MAGIC[8*hdr_pos[1:0] +: 8])
                begin
                    magic_bad = 1'b1;
                    r.kind = KIND_BAD_MAGIC;
                    expected_results.push_back(r);
                    return;
                end
            end
            else
                total_len[8*hdr_pos[1:0] +: 8] = b;
            hdr_pos = hdr_pos + 4'd1;
            return;
        end
        if (total_out >= total_len)
            return;
        case (parse_state)
            TOKEN_START:
            begin
                if (flag_count == 4'd0)
                begin
                    flag_shift = b;
                    flag_count = 4'd8;
                end
                else
                begin
                    flag_count = flag_count - 4'd1;
                    if (flag_shift[0])
                    begin
                        flag_shift = flag_shift >> 1;
                        push_data(b);
                    end
                    else
                    begin
                        flag_shift = flag_shift >> 1;
                        span_low = b;
                        parse_state = MATCH_HIGH;
                    end
                end
            end
            MATCH_HIGH:
            begin
                // back-reference wraps around the window
                win_rd = win_wr - PTR_W'({b[7:4], span_low}) - 1'b1;
                if (b[3:0] == 4'hF)
                    parse_state = MATCH_EXTRA;
                else
                    start_copy(9'(b[3:0]) + 9'd3);
            end
            default:
                start_copy(9'(b) + 9'd18);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    task automatic add_item(input logic [1:0] op, input logic [7:0] b);
        in_item_t it;
        it.operation = op;
        it.source_byte = b;
        compressed_items.push_back(it);
    endtask

    task automatic add_header(input logic [31:0] len);
        for (int i = 0; i < 4; i++)
            add_item(OP_SOURCE, STREAM_MAGIC[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            add_item(OP_SOURCE, len[8*i +: 8]);
    endtask

    // One well-formed stream with random content. Matches get their full
    // run of drains, sprinkled with refused bytes and unused operations.
    // Some streams are cut short; some run on past their length.
    task automatic add_stream();
        logic [31:0] len;
        logic [7:0]  flags;
        logic [3:0]  nib;
        logic [7:0]  ext;
        int goal;
        int made;
        int span;
        int run;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            len = $urandom();
        else if (pick < 10)
            len = $urandom_range(150, 400);
        else
            len = $urandom_range(1, 48);
        goal = (len > 400) ? $urandom_range(8, 48) : int'(len);
        if ($urandom_range(0, 9) == 0)
            goal = $urandom_range(0, goal);
        add_item(OP_START, 8'($urandom()));
        add_header(len);
        made = 0;
        while (made < goal)
        begin
            flags = 8'($urandom());
            add_item(OP_SOURCE, flags);
            for (int t = 0; t < 8 && made < goal; t++)
            begin
                if (flags[t])
                begin
                    add_item(OP_SOURCE, 8'($urandom()));
                    made++;
                end
                else
                begin
                    // mostly near references; some reach unwritten window
                    if (made > 0 && $urandom_range(0, 4) != 0)
                        span = $urandom_range(1, made);
                    else
                        span = $urandom_range(1, WINDOW_BYTES);
                    nib = ($urandom_range(0, 6) == 0) ? 4'hF : 4'($urandom_range(0, 14));
                    ext = ($urandom_range(0, 9) == 0) ? 8'($urandom()) :
                                                        8'($urandom_range(0, 15));
                    run = (nib == 4'hF) ? int'(ext) + 18 : int'(nib) + 3;
                    add_item(OP_SOURCE, 8'(span - 1));
                    add_item(OP_SOURCE, {4'((span - 1) >> 8), nib});
                    if (nib == 4'hF)
                        add_item(OP_SOURCE, ext);
                    made += run;
                    for (int d = 1; d < run; d++)
                    begin
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            add_item(OP_SOURCE, 8'($urandom()));
                        else if (pick == 1)
                            add_item(OP_UNUSED, 8'($urandom()));
                        add_item(OP_DRAIN, 8'($urandom()));
                    end
                end
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                add_item(2'($urandom_range(1, 3)), 8'($urandom()));
    endtask

    task automatic add_bad_magic();
        int pos;
        logic [7:0] flip;
        pos = $urandom_range(0, 3);
        flip = 8'($urandom_range(1, 255));
        add_item(OP_START, 8'($urandom()));
        for (int i = 0; i < pos; i++)
            add_item(OP_SOURCE, STREAM_MAGIC[8*i +: 8]);
        add_item(OP_SOURCE, STREAM_MAGIC[8*pos +: 8] ^ flip);
        // everything until the next start is dropped
        repeat ($urandom_range(1, 6))
            add_item(2'($urandom_range(1, 3)), 8'($urandom()));
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them, now and
    // then a long burst with no gaps at all. A transfer on this edge is
    // fed to the predictor before the next item is put up.
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (src_valid && src_ready)
            decode_step(src_item);
        if (!rst_n)
            src_valid <= 1'b0;
        else if (!src_valid || src_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                src_valid <= 1'b0;
            end
            else if (compressed_items.size() > 0)
            begin
                src_item <= compressed_items.pop_front();
                src_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                                                $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                src_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: switches between steady, choppy and mostly stalled
    // stretches, each of random length.
    // ---------------------------------------------------------------
    rx_mode_t rx_mode = RX_STEADY;
    int rx_span = 0;

    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_span = $urandom_range(32, 256);
        end
        else
            rx_span--;
        case (rx_mode)
            RX_STEADY:  res_ready <= 1'b1;
            RX_CHOPPY:  res_ready <= 1'($urandom_range(0, 1));
            default:    res_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // ---------------------------------------------------------------
    // Result check: each transfer against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with none expected: kind %0d byte %02h",
                                          res_item.kind, res_item.data_byte));
            else
            begin
                want = expected_results.pop_front();
                if (res_item.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", res_item.kind, want.kind));
                if (res_item.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              res_item.data_byte, want.data_byte));
                if (res_item.last_byte !== want.last_byte)
                    report_mismatch($sformatf("last_byte %0b, want %0b",
                                              res_item.last_byte, want.last_byte));
                if (res_item.run_pending !== want.run_pending)
                    report_mismatch($sformatf("run_pending %0b, want %0b",
                                              res_item.run_pending, want.run_pending));
            end
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Build all stimulus, release reset, then wait for the pipe to empty.
    // ---------------------------------------------------------------
    initial
    begin : stimulus_and_finish
        int pick;
        clear_decoder();

        // No start first: the reset state must behave like one.
        add_item(OP_DRAIN, 8'h00);          // drain with nothing pending
        add_header(32'd6);
        add_item(OP_SOURCE, 8'b1111_1001);  // literal, match, match, literals
        add_item(OP_SOURCE, 8'hFF);         // literal
        add_item(OP_SOURCE, 8'h00);         // match back one, three bytes
        add_item(OP_SOURCE, 8'h00);
        add_item(OP_SOURCE, 8'hA5);         // refused while copy pending
        add_item(OP_UNUSED, 8'h5A);
        add_item(OP_DRAIN, 8'hFF);
        add_item(OP_DRAIN, 8'h00);
        add_item(OP_DRAIN, 8'hFF);          // nothing left to drain
        add_item(OP_SOURCE, 8'hFF);         // farthest reference, long form:
        add_item(OP_SOURCE, 8'hFF);         // wraps onto bytes never written
        add_item(OP_SOURCE, 8'hFF);         // longest run
        add_item(OP_DRAIN, 8'h00);          // reaches the length: rest discarded
        add_item(OP_DRAIN, 8'h00);
        add_item(OP_SOURCE, 8'h12);         // past the end: dropped
        // bad magic, then input ignored
        add_item(OP_START, 8'h00);
        add_item(OP_SOURCE, 8'h4E);
        add_item(OP_SOURCE, 8'h51);
        add_item(OP_SOURCE, 8'h4B);
        add_item(OP_DRAIN, 8'h00);

        while (compressed_items.size() < STIMULUS_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                add_stream();
            else if (pick < 85)
                add_bad_magic();
            else if (pick < 92)
            begin
                // zero length: no output at all
                add_item(OP_START, 8'($urandom()));
                add_header(32'd0);
                repeat ($urandom_range(1, 5))
                    add_item(2'($urandom_range(1, 3)), 8'($urandom()));
            end
            else
                repeat ($urandom_range(4, 12))
                    add_item(2'($urandom_range(0, 3)), 8'($urandom()));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (compressed_items.size() != 0 || src_valid || expected_results.size() != 0);

        // catch stray results that show up late
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lzss_pkg.sv
hdl/lzss_ram.sv
hdl/lzss_fifo.sv
hdl/lzss_front.sv
hdl/lzss_back.sv
hdl/lzss_stream_decoder.sv
sim/lzss_stream_decoder_test.sv
